### design/kcl_pkg.sv
// Package for the keypad code lock: payload word types, mode encoding,
// key and register codes, and the power-up code digits. No dependencies.
package kcl_pkg;

  localparam int unsigned KCL_CODE_LENGTH = 4;

  // Input word: a timer tick (command 0) or a key press (command 1)
  typedef struct packed {
    logic       command;
    logic [7:0] key_code;
  } kcl_in_t;

  // Result word, one per accepted input word
  typedef struct packed {
    logic [2:0] lock_mode;
    logic       door_open;
    logic [2:0] digits_entered;
  } kcl_out_t;

  // Internal lock mode, one-hot
  typedef enum logic [5:0] {
    MODE_CLOSED = 6'b000001,
    MODE_OPEN   = 6'b000010,
    MODE_DENIED = 6'b000100,
    MODE_VERIFY = 6'b001000,
    MODE_ENTER  = 6'b010000,
    MODE_SAVED  = 6'b100000
  } mode_t;

  // Mode codes as seen on the result word
  localparam logic [2:0] LOCK_CLOSED = 3'd0;
  localparam logic [2:0] LOCK_OPEN   = 3'd1;
  localparam logic [2:0] LOCK_DENIED = 3'd2;
  localparam logic [2:0] LOCK_VERIFY = 3'd3;
  localparam logic [2:0] LOCK_ENTER  = 3'd4;
  localparam logic [2:0] LOCK_SAVED  = 3'd5;

  // Special keys (ASCII)
  localparam logic [7:0] KEY_CHANGE  = 8'h44;  // 'D'
  localparam logic [7:0] KEY_CANCEL  = 8'h23;  // '#'
  localparam logic [7:0] KEY_RESTART = 8'h2A;  // '*'
  localparam logic [7:0] KEY_BLANK   = 8'h20;  // space, staging buffer fill

  // Configuration register indexes
  localparam logic [2:0] CFG_OPEN_TICKS    = 3'd0;
  localparam logic [2:0] CFG_DENIED_TICKS  = 3'd1;
  localparam logic [2:0] CFG_SAVED_TICKS   = 3'd2;
  localparam logic [2:0] CFG_TIMEOUT_TICKS = 3'd3;

  // Power-up code "2580", padded with '0' for longer codes
  function automatic logic [7:0] initial_digit(input int unsigned pos);
    case (pos)
      0:       initial_digit = 8'h32;
      1:       initial_digit = 8'h35;
      2:       initial_digit = 8'h38;
      default: initial_digit = 8'h30;
    endcase
  endfunction

  function automatic logic [2:0] mode_code(input mode_t m);
    unique case (m)
      MODE_CLOSED: mode_code = LOCK_CLOSED;
      MODE_OPEN:   mode_code = LOCK_OPEN;
      MODE_DENIED: mode_code = LOCK_DENIED;
      MODE_VERIFY: mode_code = LOCK_VERIFY;
      MODE_ENTER:  mode_code = LOCK_ENTER;
      MODE_SAVED:  mode_code = LOCK_SAVED;
      default:     mode_code = LOCK_CLOSED;
    endcase
  endfunction

endpackage

### design/keypad_code_lock_unit.sv
// Keypad code lock: top level, all lock state and the result register.
// Depends on kcl_pkg.
//
//   channel  | direction | handshake          | word
//   ---------+-----------+--------------------+-----------------------------------
//   in       | input     | in_valid/in_stall  | kcl_in_t  {command, key_code}
//   out      | output    | out_valid/out_stall| kcl_out_t {lock_mode, door_open,
//            |           |                    |            digits_entered}
//   cfg      | input     | cfg_en             | cfg_index, cfg_data (8 bit)
//
// One word is accepted per cycle unless in_stall is high; its result shows
// on out in the next cycle. The rate is set by the single result register:
// a new word enters while the previous result is being taken, and in_stall
// rises only while a result waits under out_stall. Synchronous reset restores
// the code "2580", the default tick counts and the closed mode; no clearing pass.
module keypad_code_lock_unit #(
  parameter int unsigned CODE_LENGTH = kcl_pkg::KCL_CODE_LENGTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  kcl_pkg::kcl_in_t in_word,
  output logic             out_valid,
  input  logic             out_stall,
  output kcl_pkg::kcl_out_t out_word,
  input  logic             cfg_en,
  input  logic [2:0]       cfg_index,
  input  logic [7:0]       cfg_data
);

  import kcl_pkg::*;

  // Compare index covers the code positions; staged count also holds "full".
  localparam int unsigned IDX_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
  localparam int unsigned CNT_W = $clog2(CODE_LENGTH + 1);

  // Configuration
  logic [7:0] open_ticks;
  logic [7:0] denied_ticks;
  logic [7:0] saved_ticks;
  logic [7:0] timeout_ticks;

  // Lock state
  mode_t            mode;
  logic [7:0]       elapsed;
  logic [IDX_W-1:0] compare_index;
  logic             all_matched;
  logic [CNT_W-1:0] staged_count;
  logic [7:0]       stored_code [CODE_LENGTH];
  logic [7:0]       staged_code [CODE_LENGTH];

  // Next values and update strobes
  mode_t            mode_next;
  logic [7:0]       elapsed_next;
  logic [IDX_W-1:0] compare_index_next;
  logic             all_matched_next;
  logic [CNT_W-1:0] staged_count_next;
  logic             stage_we;
  logic             commit;
  logic             out_valid_next;
  kcl_out_t         result;

  // Datapath helpers
  logic             in_fire;
  logic             is_key;
  logic [7:0]       key;
  logic [7:0]       tick_count;
  logic [7:0]       elapsed_check;
  logic             matched;
  logic             last_pos;
  logic             buffer_full;
  logic             go;
  mode_t            target;
  mode_t            check_target;
  logic [IDX_W-1:0] idx_step;
  logic             am_step;
  logic [CNT_W-1:0] cnt_step;
  logic [CNT_W+2:0] cnt_wide;

  // Accept whenever the result register is free or being drained this cycle.
  assign in_stall = out_valid && out_stall;
  assign in_fire  = in_valid && !in_stall;
  assign is_key   = in_word.command;
  assign key      = in_word.key_code;

  always_comb begin
    // Ticks advance the counter, saturating at the top.
    tick_count = elapsed;
    if (!is_key && (elapsed != 8'hFF)) begin
      tick_count = elapsed + 8'd1;
    end

    // Code compare for closed and verify modes
    matched     = all_matched && (stored_code[compare_index] == key);
    last_pos    = (compare_index == IDX_W'(CODE_LENGTH - 1));
    buffer_full = (staged_count == CNT_W'(CODE_LENGTH));
    if (!matched) begin
      check_target = MODE_DENIED;
    end else if (mode == MODE_CLOSED) begin
      check_target = MODE_OPEN;
    end else begin
      check_target = MODE_ENTER;
    end

    go       = 1'b0;
    target   = MODE_CLOSED;
    idx_step = compare_index;
    am_step  = all_matched;
    cnt_step = staged_count;
    stage_we = 1'b0;
    commit   = 1'b0;

    unique case (mode)
      MODE_CLOSED, MODE_VERIFY: begin
        if (is_key) begin
          if ((mode == MODE_CLOSED) && (key == KEY_CHANGE)) begin
            go     = 1'b1;
            target = MODE_VERIFY;
          end else if (last_pos) begin
            go     = 1'b1;
            target = check_target;
          end else begin
            idx_step = compare_index + IDX_W'(1);
            am_step  = matched;
          end
        end
      end
      MODE_OPEN: begin
        if (tick_count >= open_ticks) begin
          go = 1'b1;
        end
      end
      MODE_DENIED: begin
        if (tick_count >= denied_ticks) begin
          go = 1'b1;
        end
      end
      MODE_SAVED: begin
        if (tick_count >= saved_ticks) begin
          go = 1'b1;
        end
      end
      MODE_ENTER: begin
        if (is_key) begin
          if (key == KEY_CANCEL) begin
            go = 1'b1;
          end else if ((key == KEY_CHANGE) && buffer_full) begin
            commit = 1'b1;
            go     = 1'b1;
            target = MODE_SAVED;
          end else if ((key != KEY_RESTART) && !buffer_full) begin
            stage_we = 1'b1;
            cnt_step = staged_count + CNT_W'(1);
          end else begin
            go     = 1'b1;
            target = MODE_VERIFY;
          end
        end
      end
      default: begin
        go = 1'b1;
      end
    endcase

    // Timeout is checked after the mode's own action; a mode change has
    // already cleared the counter.
    elapsed_check = go ? 8'd0 : tick_count;
    if (elapsed_check >= timeout_ticks) begin
      go     = 1'b1;
      target = MODE_CLOSED;
    end

    // Entering any mode clears the per-mode state.
    if (go) begin
      mode_next          = target;
      elapsed_next       = 8'd0;
      compare_index_next = '0;
      all_matched_next   = 1'b1;
      staged_count_next  = '0;
    end else begin
      mode_next          = mode;
      elapsed_next       = tick_count;
      compare_index_next = idx_step;
      all_matched_next   = am_step;
      staged_count_next  = cnt_step;
    end

    cnt_wide              = {3'b000, staged_count_next};
    result.lock_mode      = mode_code(mode_next);
    result.door_open      = (mode_next == MODE_OPEN);
    result.digits_entered = cnt_wide[2:0];

    // Hold a stalled result, drop a taken one.
    if (in_fire) begin
      out_valid_next = 1'b1;
    end else if (out_stall) begin
      out_valid_next = out_valid;
    end else begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_ticks    <= 8'd5;
      denied_ticks  <= 8'd2;
      saved_ticks   <= 8'd5;
      timeout_ticks <= 8'd15;
      mode          <= MODE_CLOSED;
      elapsed       <= 8'd0;
      compare_index <= '0;
      all_matched   <= 1'b1;
      staged_count  <= '0;
      out_valid     <= 1'b0;
      for (int unsigned i = 0; i < CODE_LENGTH; i++) begin
        stored_code[i] <= initial_digit(i);
        staged_code[i] <= KEY_BLANK;
      end
    end else begin
      if (cfg_en) begin
        unique case (cfg_index)
          CFG_OPEN_TICKS:    open_ticks    <= cfg_data;
          CFG_DENIED_TICKS:  denied_ticks  <= cfg_data;
          CFG_SAVED_TICKS:   saved_ticks   <= cfg_data;
          CFG_TIMEOUT_TICKS: timeout_ticks <= cfg_data;
          default: ;
        endcase
      end
      if (in_fire) begin
        mode          <= mode_next;
        elapsed       <= elapsed_next;
        compare_index <= compare_index_next;
        all_matched   <= all_matched_next;
        staged_count  <= staged_count_next;
        if (stage_we) begin
          staged_code[staged_count[IDX_W-1:0]] <= key;
        end
        // Commit the full staging buffer as the new code.
        if (commit) begin
          for (int unsigned i = 0; i < CODE_LENGTH; i++) begin
            stored_code[i] <= staged_code[i];
          end
        end
      end
      out_valid <= out_valid_next;
    end
  end

  // Result payload, loaded on accept
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_word <= result;
    end
  end

  // Door output agrees with the reported mode.
  a_door_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_word.door_open == (out_word.lock_mode == LOCK_OPEN)))
    else $error("door_open disagrees with lock_mode");

  // Staged digits exist only during new-code entry.
  a_staged_enter: assert property (@(posedge clk) disable iff (rst)
    (staged_count != '0) |-> (mode == MODE_ENTER))
    else $error("staged digits outside enter mode");

  // Compare progress only while checking a code.
  a_index_mode: assert property (@(posedge clk) disable iff (rst)
    (compare_index != '0) |-> ((mode == MODE_CLOSED) || (mode == MODE_VERIFY)))
    else $error("compare index outside code check");

  // Every accepted word yields a result in the next cycle.
  a_fire_result: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid)
    else $error("accepted word produced no result");

  // Timed modes never keep a counter at or past the timeout.
  a_timeout: assert property (@(posedge clk) disable iff (rst)
    (in_fire && (mode_next != MODE_CLOSED)) |-> (elapsed_next < timeout_ticks))
    else $error("timeout not taken");

endmodule
